### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition that holds on every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

### rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// types, constants and elaboration-time tables of the uv sphere vertex generator
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_RES = 256;
  localparam int SINE_TABLE_DEPTH = 1025;
  localparam int QUARTER = SINE_TABLE_DEPTH - 1;
  localparam int QTR_W = $clog2(QUARTER);
  localparam int IDX_W = QTR_W + 2;
  localparam int ROM_AW = QTR_W + 1;
  localparam int RES_W = 9;
  localparam int RECIP_W = 31;
  localparam int RECIP_DEPTH = 1 << RES_W;
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned SINE_STEP = (PI_Q60 >> 1) / QUARTER;

  typedef logic [14:0] sine_rom_t [0:SINE_TABLE_DEPTH-1];
  typedef logic [RECIP_W-1:0] recip_rom_t [0:RECIP_DEPTH-1];

  typedef struct packed {
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [16:0] corner_here;
    logic [16:0] corner_next_seg;
    logic        quad_valid;
  } side_t;

  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl;
    ah = a >> 32;
    al = a & 64'hFFFF_FFFF;
    bh = b >> 32;
    bl = b & 64'hFFFF_FFFF;
    return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
  endfunction

  // restoring shift-subtract quotient, used only while building tables
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t       rom;
    longint unsigned x, x2, term, sum, den;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x = SINE_STEP * longint'(k);
      x2 = mul_q60(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 24; n++) begin
        if (term != 0) begin
          den = longint'(2 * n) * longint'(2 * n + 1);
          term = div_u64(mul_q60(term, x2), den);
          if (n % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
      rom[k] = 15'((sum + (64'd1 << 45)) >> 46);
    end
    return rom;
  endfunction

  function automatic recip_rom_t build_recip();
    recip_rom_t      rom;
    longint unsigned r;
    for (int i = 0; i < RECIP_DEPTH; i++) begin
      r = longint'(i);
      if (i < 3) rom[i] = '0;
      else rom[i] = RECIP_W'(div_u64((64'd1 << 32) + r - 1, r));
    end
    return rom;
  endfunction

endpackage

### rtl/core/uvs_sincos.sv
// ----------------------------------------------------------------------------
// uvs_sincos
// sine and cosine of a turn index from a registered quarter-wave rom
// ----------------------------------------------------------------------------
module uvs_sincos (
  input  logic                      clk,
  input  logic [uvs_pkg::IDX_W-1:0] idx,
  output logic signed [15:0]        sin_val,
  output logic signed [15:0]        cos_val
);
  import uvs_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine();

  logic [IDX_W-1:0]  cidx;
  logic [ROM_AW-1:0] s_addr, c_addr;
  logic [14:0]       s_mag, c_mag;
  logic              s_neg, c_neg;

  assign cidx = idx + IDX_W'(QUARTER);
  assign s_addr = idx[QTR_W] ? ROM_AW'(QUARTER) - ROM_AW'(idx[QTR_W-1:0])
                             : ROM_AW'(idx[QTR_W-1:0]);
  assign c_addr = cidx[QTR_W] ? ROM_AW'(QUARTER) - ROM_AW'(cidx[QTR_W-1:0])
                              : ROM_AW'(cidx[QTR_W-1:0]);

  always_ff @(posedge clk) begin
    s_mag <= SINE_ROM[s_addr];
    c_mag <= SINE_ROM[c_addr];
    s_neg <= idx[IDX_W-1];
    c_neg <= cidx[IDX_W-1];
  end

  assign sin_val = s_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  assign cos_val = c_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

endmodule

### rtl/core/uv_sphere_vertex_gen.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_gen
// one uv sphere vertex, normal, texture coordinates and quad corners per grid point
// ----------------------------------------------------------------------------
// usage:
//   write resolution with resolution_we while no transaction is in flight;
//   values below 3 act as 3 and values above MAX_RES act as MAX_RES.
//   a transaction is taken at each edge where start is high and busy is low.
//   busy is never raised, so a new grid point may enter every cycle.
//   results leave the last register stage, each held for exactly one cycle
//   and marked by done; the receiver cannot stall the pipeline.
//   throughput is one vertex per cycle through six register stages:
//   clamp, reciprocal multiply, quotient correction, sine rom read,
//   normal product, rounding.
//   divisions by the resolution use a reciprocal looked up when the
//   register is written.
//   reset clears all stage valid bits and sets resolution to 32.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_gen (
  input  logic               clk,
  input  logic               rst,
  input  logic               resolution_we,
  input  logic [8:0]         resolution_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [8:0]         ring,
  input  logic [7:0]         segment,
  output logic               done,
  output logic signed [14:0] pos_x,
  output logic signed [14:0] pos_y,
  output logic signed [14:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic [16:0]        corner_here,
  output logic [16:0]        corner_next_seg,
  output logic               quad_valid
);
  import uvs_pkg::*;

  localparam recip_rom_t RECIP_ROM = build_recip();

  logic [RES_W-1:0]   res;
  logic [RECIP_W-1:0] recip;
  logic [RES_W-1:0]   res_next;

  logic va, vb, vc, vd, ve, vf;

  logic [8:0] a_ring, a_useg, a_vnum;
  logic [7:0] a_seg;
  logic       a_qv;

  logic [16:0] b_pt, b_pp, b_u, b_v, b_base;
  logic [8:0]  b_ring, b_useg, b_vnum;
  logic [7:0]  b_seg, b_nseg;
  logic        b_qv;

  logic [15:0] c_pt, c_pp;
  side_t       c_side, d_side, e_side;

  logic signed [15:0] st, ct, sp, cp;
  logic signed [31:0] e_px, e_pz;
  logic signed [15:0] e_ny;

  logic [8:0] ring_c, useg_c;
  logic [7:0] seg_c;
  logic [31:0] rx, rz;
  logic signed [15:0] nx, nz;

  assign busy = 1'b0;

  always_comb begin
    res_next = resolution_wdata;
    if (resolution_wdata < RES_W'(3)) res_next = RES_W'(3);
    else if (resolution_wdata > RES_W'(MAX_RES)) res_next = RES_W'(MAX_RES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= RES_W'(32);
      recip <= RECIP_ROM[32];
    end else if (resolution_we) begin
      res <= res_next;
      recip <= RECIP_ROM[res_next];
    end
  end

  // clamp stage
  always_comb begin
    ring_c = (ring > res) ? res : ring;
    seg_c = ({1'b0, segment} >= res) ? 8'(res - 9'd1) : segment;
    useg_c = ({1'b0, seg_c} <= (res >> 1)) ? {1'b0, seg_c} : res - {1'b0, seg_c};
  end

  always_ff @(posedge clk) begin
    a_ring <= ring_c;
    a_seg <= seg_c;
    a_useg <= useg_c;
    a_vnum <= res - ring_c;
    a_qv <= ring_c < res;
  end

  // reciprocal multiply stage
  always_ff @(posedge clk) begin
    b_pt <= 17'((40'(a_ring) * 40'(recip)) >> 17);
    b_pp <= 17'((40'(a_seg) * 40'(recip)) >> 16);
    b_u <= 17'((40'(a_useg) * 40'(recip)) >> 16);
    b_v <= 17'((40'(a_vnum) * 40'(recip)) >> 17);
    b_base <= 17'(18'(a_ring) * 18'(res));
    b_nseg <= ({1'b0, a_seg} + 9'd1 >= res) ? 8'd0 : a_seg + 8'd1;
    b_ring <= a_ring;
    b_seg <= a_seg;
    b_useg <= a_useg;
    b_vnum <= a_vnum;
    b_qv <= a_qv;
  end

  // quotient correction stage
  function automatic logic [15:0] fix_q(logic [16:0] q0, logic [24:0] num,
                                        logic [RES_W-1:0] d);
    logic [25:0] prod;
    prod = 26'(q0) * 26'(d);
    return (prod > 26'(num)) ? 16'(q0 - 17'd1) : 16'(q0);
  endfunction

  always_ff @(posedge clk) begin
    c_pt <= fix_q(b_pt, {1'b0, b_ring, 15'd0}, res);
    c_pp <= fix_q(b_pp, {1'b0, b_seg, 16'd0}, res);
    c_side.tex_u <= fix_q(b_u, {b_useg, 16'd0}, res);
    c_side.tex_v <= fix_q(b_v, {1'b0, b_vnum, 15'd0}, res);
    c_side.corner_here <= b_base + 17'(b_seg);
    c_side.corner_next_seg <= b_base + 17'(b_nseg);
    c_side.quad_valid <= b_qv;
  end

  // rom read stage
  uvs_sincos u_theta (
    .clk     (clk),
    .idx     (c_pt[15 -: IDX_W]),
    .sin_val (st),
    .cos_val (ct)
  );

  uvs_sincos u_phi (
    .clk     (clk),
    .idx     (c_pp[15 -: IDX_W]),
    .sin_val (sp),
    .cos_val (cp)
  );

  always_ff @(posedge clk) begin
    d_side <= c_side;
  end

  // product stage
  always_ff @(posedge clk) begin
    e_px <= st * sp;
    e_pz <= st * cp;
    e_ny <= ct;
    e_side <= d_side;
  end

  // rounding stage
  always_comb begin
    rx = 32'(e_px) + 32'd8192;
    rz = 32'(e_pz) + 32'd8192;
    nx = 16'($signed(rx) >>> 14);
    nz = 16'($signed(rz) >>> 14);
  end

  always_ff @(posedge clk) begin
    norm_x <= nx;
    norm_y <= e_ny;
    norm_z <= nz;
    pos_x <= nx[15:1];
    pos_y <= e_ny[15:1];
    pos_z <= nz[15:1];
    tex_u <= e_side.tex_u;
    tex_v <= e_side.tex_v;
    corner_here <= e_side.corner_here;
    corner_next_seg <= e_side.corner_next_seg;
    quad_valid <= e_side.quad_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      va <= start && !busy;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  assign done = vf;

endmodule

### rtl/core/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker
// port-level checks of the uv sphere vertex generator
// ----------------------------------------------------------------------------
module uvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] tex_u,
  input logic [15:0] tex_v
);
  `include "assert_macros.svh"

  `CHK_ALWAYS(a_never_busy, clk, rst, !busy)
  `CHK_IMPLY(a_done_has_start, clk, rst, done, $past(start && !busy, 6))
  `CHK_IMPLY(a_start_gives_done, clk, rst, start && !busy, ##6 done)
  `CHK_IMPLY(a_tex_range, clk, rst, done, tex_u <= 16'd32768 && tex_v <= 16'd32768)

endmodule

bind uv_sphere_vertex_gen uvs_checker u_uvs_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .tex_u (tex_u),
  .tex_v (tex_v)
);

### tb/uv_sphere_vertex_gen_tb.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_gen_tb
// self-checking bench for the uv sphere vertex generator: a directed table
// of grid points, then random grid points under several resolutions, each
// vertex checked field by field against a pinned vertex or in-bench calculator
// ----------------------------------------------------------------------------
module uv_sphere_vertex_gen_tb;

  localparam int MAX_RES    = 256;
  localparam int QTR        = 1024;
  localparam int CYCLE_CAP  = 200000;
  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [14:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [16:0]        corner_here;
    logic [16:0]        corner_next_seg;
    logic               quad_valid;
  } vertex_t;

  typedef struct {
    logic [8:0] ring;
    logic [7:0] seg;
    logic       pinned;
    vertex_t    vtx;
  } grid_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic resolution_we = 1'b0;
  logic [8:0] resolution_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [8:0] ring = '0;
  logic [7:0] segment = '0;
  logic done;
  logic signed [14:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [15:0] tex_u, tex_v;
  logic [16:0] corner_here, corner_next_seg;
  logic quad_valid;

  logic pinned = 1'b0;
  vertex_t pinned_vtx = '0;

  int sine_q [0:QTR];
  int res_shadow = 32;
  vertex_t vertex_queue [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  always #1 clk = ~clk;

  uv_sphere_vertex_gen u_dut (
    .clk(clk), .rst(rst),
    .resolution_we(resolution_we), .resolution_wdata(resolution_wdata),
    .start(start), .busy(busy), .ring(ring), .segment(segment),
    .done(done),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v),
    .corner_here(corner_here), .corner_next_seg(corner_next_seg),
    .quad_valid(quad_valid)
  );

  function automatic int wave(int idx);
    int q, r, v;
    idx = idx % (4 * QTR);
    q = idx / QTR;
    r = idx % QTR;
    if (q % 2 == 1) r = QTR - r;
    v = sine_q[r];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic vertex_t sphere_vertex(int res_reg, int rg, int sg);
    vertex_t v;
    int res, pt, pp, st, ct, sp, cp, nx, ny, nz, u, base, nseg;
    res = res_reg;
    if (res < 3) res = 3;
    if (res > MAX_RES) res = MAX_RES;
    if (rg > res) rg = res;
    if (sg >= res) sg = res - 1;
    pt = (rg * 32768) / res;
    pp = (sg * 65536) / res;
    st = wave(pt >> 4);
    ct = wave((pt >> 4) + QTR);
    sp = wave(pp >> 4);
    cp = wave((pp >> 4) + QTR);
    nx = (st * sp + 8192) >>> 14;
    ny = ct;
    nz = (st * cp + 8192) >>> 14;
    u = (sg <= res / 2) ? (sg * 65536) / res : ((res - sg) * 65536) / res;
    base = rg * res;
    nseg = (sg + 1 >= res) ? 0 : sg + 1;
    v.pos_x = 15'(nx >>> 1);
    v.pos_y = 15'(ny >>> 1);
    v.pos_z = 15'(nz >>> 1);
    v.norm_x = 16'(nx);
    v.norm_y = 16'(ny);
    v.norm_z = 16'(nz);
    v.tex_u = 16'(u);
    v.tex_v = 16'(((res - rg) * 32768) / res);
    v.corner_here = 17'(base + sg);
    v.corner_next_seg = 17'(base + nseg);
    v.quad_valid = (rg < res);
    return v;
  endfunction

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_t w;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
    if (!rst) begin
      if (resolution_we) res_shadow = resolution_wdata;
      if (start && !busy)
        vertex_queue.insert(vertex_queue.size(),
          pinned ? pinned_vtx : sphere_vertex(res_shadow, ring, segment));
      if (done) begin
        if (vertex_queue.size() == 0) begin
          report("done with no transaction pending", 1, 0);
        end else begin
          w = vertex_queue.pop_front();
          if (pos_x !== w.pos_x) report("pos_x", pos_x, w.pos_x);
          if (pos_y !== w.pos_y) report("pos_y", pos_y, w.pos_y);
          if (pos_z !== w.pos_z) report("pos_z", pos_z, w.pos_z);
          if (norm_x !== w.norm_x) report("norm_x", norm_x, w.norm_x);
          if (norm_y !== w.norm_y) report("norm_y", norm_y, w.norm_y);
          if (norm_z !== w.norm_z) report("norm_z", norm_z, w.norm_z);
          if (tex_u !== w.tex_u) report("tex_u", tex_u, w.tex_u);
          if (tex_v !== w.tex_v) report("tex_v", tex_v, w.tex_v);
          if (corner_here !== w.corner_here)
            report("corner_here", corner_here, w.corner_here);
          if (corner_next_seg !== w.corner_next_seg)
            report("corner_next_seg", corner_next_seg, w.corner_next_seg);
          if (quad_valid !== w.quad_valid) report("quad_valid", quad_valid, w.quad_valid);
        end
      end
    end
  end

  // transaction stays offered until taken; start is left high for the next one
  task automatic send(logic [8:0] rg, logic [7:0] sg, logic pin, vertex_t pv);
    start <= 1'b1;
    ring <= rg;
    segment <= sg;
    pinned <= pin;
    pinned_vtx <= pv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    pinned <= 1'b0;
    @(posedge clk);
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_res(int value);
    resolution_we <= 1'b1;
    resolution_wdata <= 9'(value);
    @(posedge clk);
    resolution_we <= 1'b0;
  endtask

  grid_row_t grid_table [$];
  int res_list [$] = '{3, 256, 0, 1, 2, 511, 257, 4, 100, 17, 255};

  initial begin
    vertex_t at_pole, at_base;
    grid_row_t row;
    int res_now, rg, sg;
    for (int k = 0; k <= QTR; k++)
      sine_q[k] = $rtoi(16384.0 * $sin(3.14159265358979323846 * k / 2048.0) + 0.5);

    // top pole and last ring at the reset resolution of 32
    at_pole = '{15'sd0, 15'sd8192, 15'sd0, 16'sd0, 16'sd16384, 16'sd0,
                16'd0, 16'd32768, 17'd0, 17'd1, 1'b1};
    at_base = '{15'sd0, -15'sd8192, 15'sd0, 16'sd0, -16'sd16384, 16'sd0,
                16'd0, 16'd0, 17'd1024, 17'd1025, 1'b0};
    grid_table = '{
      '{9'd0,   8'd0,   1'b1, at_pole},
      '{9'd32,  8'd0,   1'b1, at_base},
      '{9'd511, 8'd0,   1'b1, at_base},
      '{9'd33,  8'd0,   1'b1, at_base},
      '{9'd0,   8'd31,  1'b0, '0},
      '{9'd0,   8'd255, 1'b0, '0},
      '{9'd32,  8'd31,  1'b0, '0},
      '{9'd511, 8'd255, 1'b0, '0},
      '{9'd256, 8'd128, 1'b0, '0},
      '{9'd16,  8'd0,   1'b0, '0},
      '{9'd16,  8'd8,   1'b0, '0},
      '{9'd16,  8'd16,  1'b0, '0},
      '{9'd16,  8'd17,  1'b0, '0},
      '{9'd8,   8'd24,  1'b0, '0},
      '{9'd31,  8'd1,   1'b0, '0},
      '{9'd1,   8'd30,  1'b0, '0},
      '{9'd170, 8'd85,  1'b0, '0},
      '{9'd85,  8'd170, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (grid_table[i]) begin
      row = grid_table[i];
      send(row.ring, row.seg, row.pinned, row.vtx);
      maybe_idle();
    end
    drain();

    foreach (res_list[p]) begin
      res_now = (p == res_list.size() - 1) ? $urandom_range(511) : res_list[p];
      write_res(res_now);
      if (p == res_list.size() - 2) calm = 1;
      for (int n = 0; n < 45; n++) begin
        case ($urandom_range(9))
          0: begin rg = $urandom_range(511); sg = $urandom_range(255); end
          1: begin rg = $urandom_range(1) ? 0 : 511; sg = $urandom_range(1) ? 0 : 255; end
          default: begin
            rg = $urandom_range((res_now > 258) ? 258 : res_now + 1);
            sg = $urandom_range((res_now > 255) ? 255 : res_now);
          end
        endcase
        send(9'(rg), 8'(sg), 1'b0, '0);
        maybe_idle();
      end
      drain();
    end

    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/uvs_pkg.sv
rtl/core/uvs_sincos.sv
rtl/core/uv_sphere_vertex_gen.sv
rtl/core/uvs_checker.sv
tb/uv_sphere_vertex_gen_tb.sv
